FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/mrrt_pkg.sv
package mrrt_pkg;

    localparam int CMD_W      = 3;
    localparam int IDX_W      = 3;
    localparam int PAGE_NUM_W = 20;
    localparam int PAGE_BITS  = 12;
    localparam int TYPE_W     = 2;
    localparam int REP_W      = 4;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int ATTR_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MASK_W     = 8;
    localparam int CNT_W      = 4;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 3'd0,
        CMD_READ      = 3'd1,
        CMD_FIND_FREE = 3'd2,
        CMD_LOAD_RAW  = 3'd3,
        CMD_VALIDATE  = 3'd4
    } cmd_t;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_WC = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_UC = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_WB = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MCR_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGES_IN_USE = 2'd2;

    localparam logic [ATTR_W-1:0] ATTR_ALL     = 5'h1f;
    localparam logic [ATTR_W-1:0] ATTR_WB_CODE = 5'd25;
    localparam logic [ATTR_W-1:0] ATTR_UC      = 5'h02;
    localparam logic [ATTR_W-1:0] ATTR_OTHER   = 5'h09;

    localparam logic [CNT_W-1:0] RANGES_RESET = 4'd8;

endpackage

FILE: design/memory_range_register_table.sv
// Memory range register table: NUM_ENTRIES entries of a low and a high 32-bit word, driven
// by one command per input transfer (write, read, find free, load raw, validate). A command
// is captured when it is accepted and then runs in the execute step, where write, read, load
// raw, validate and unknown codes finish; find free finishes there when the preferred index
// is usable or no ranges are in use, and otherwise scans the table one entry per cycle through
// the single table read port and compare unit, examining at most NUM_ENTRIES entries (the
// ranges-in-use count, capped at NUM_ENTRIES). The input is not ready while a command is at
// work; a finished result sits in the output register, and a new command is accepted while it
// waits. A command that finishes while the output register is still full holds until it is
// taken. The table is cleared by reset in the same cycle; there is no clearing pass.
module memory_range_register_table #(
    parameter int NUM_ENTRIES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Fields from bit 0: entry_index[2:0], base_page[22:3], size_pages[42:23],
    // mem_type[44:43], replace_index[48:45], raw_low[80:49], raw_high[112:81], zero pad.
    input  logic [mrrt_pkg::IN_DATA_W-1:0]    s_tdata,
    // Fields from bit 0: command[2:0].
    input  logic [mrrt_pkg::CMD_W-1:0]        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: status[1:0], found_index[4:2], base_out[24:5], size_out[44:25],
    // type_out[46:45], low_word_out[78:47], high_word_out[110:79], zero pad.
    output logic [mrrt_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [mrrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mrrt_pkg::*;

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] NUM_ENTRIES_CNT = CNT_W'(NUM_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Captured command.
    logic [CMD_W-1:0]      cmd_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [PAGE_NUM_W-1:0] base_reg;
    logic [PAGE_NUM_W-1:0] size_reg;
    logic [TYPE_W-1:0]     type_reg;
    logic [REP_W-1:0]      rep_reg;
    logic [WORD_W-1:0]     rlo_reg;
    logic [WORD_W-1:0]     rhi_reg;

    // Configuration.
    logic                  mode_reg;
    logic [MASK_W-1:0]     rmask_reg;
    logic [CNT_W-1:0]      riu_reg;

    // Table.
    logic [WORD_W-1:0] low_mem  [NUM_ENTRIES];
    logic [WORD_W-1:0] high_mem [NUM_ENTRIES];

    // Output register.
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [IDX_W-1:0]      out_found_reg, out_found_next;
    logic [PAGE_NUM_W-1:0] out_base_reg, out_base_next;
    logic [PAGE_NUM_W-1:0] out_size_reg, out_size_next;
    logic [TYPE_W-1:0]     out_type_reg, out_type_next;
    logic [WORD_W-1:0]     out_low_reg, out_low_next;
    logic [WORD_W-1:0]     out_high_reg, out_high_next;

    logic              done;
    logic              tbl_we;
    logic [WORD_W-1:0] wr_low, wr_high;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_in_tbl;
    logic [WORD_W-1:0] rd_low, rd_high;
    logic [CNT_W-1:0]  max_cnt;
    logic              out_free;
    logic              pref_ok;
    logic              scan_hit;
    logic [WORD_W-1:0] enc_low, enc_high;
    logic [TYPE_W-1:0] dec_type;
    logic [ATTR_W-1:0] attr;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_high_reg, out_low_reg, out_type_reg, out_size_reg,
                       out_base_reg, out_found_reg, out_status_reg};
    assign out_free = !out_valid_reg || m_tready;

    assign max_cnt = (riu_reg > NUM_ENTRIES_CNT) ? NUM_ENTRIES_CNT : riu_reg;
    assign pref_ok = !rep_reg[REP_W-1] && ({1'b0, rep_reg[REP_W-2:0]} < max_cnt);

    // The single table read port serves both read and the free-entry scan.
    assign rd_addr   = (state_reg == ST_SCAN) ? cnt_reg[IDX_W-1:0] : idx_reg;
    assign rd_in_tbl = ({1'b0, rd_addr} < NUM_ENTRIES_CNT);
    assign rd_low    = rd_in_tbl ? low_mem[rd_addr[AW-1:0]]  : '0;
    assign rd_high   = rd_in_tbl ? high_mem[rd_addr[AW-1:0]] : '0;

    // An unreserved entry is free when its address bits, so its decoded size, are zero.
    assign scan_hit = !rmask_reg[cnt_reg[IDX_W-1:0]]
                      && (rd_low[WORD_W-1:PAGE_BITS] == '0);

    always_comb
    begin
        attr = mode_reg ? ((type_reg == TYPE_UC) ? ATTR_UC : ATTR_OTHER) : ATTR_ALL;
        if (size_reg != '0)
        begin
            enc_high = {base_reg, {PAGE_BITS{1'b0}}};
            enc_low  = {PAGE_NUM_W'(~size_reg + 1'b1), {(PAGE_BITS-ATTR_W){1'b0}}, attr};
        end
        else
        begin
            enc_high = '0;
            enc_low  = '0;
        end
    end

    always_comb
    begin
        dec_type = TYPE_WC;
        if (mode_reg && rd_low[1])
            dec_type = TYPE_UC;
        if (mode_reg && (rd_low[ATTR_W-1:0] == ATTR_WB_CODE))
            dec_type = TYPE_WB;
        if (!mode_reg && (rd_low[ATTR_W-1:0] == ATTR_ALL))
            dec_type = TYPE_WB;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        done            = 1'b0;
        tbl_we          = 1'b0;
        wr_low          = enc_low;
        wr_high         = enc_high;
        out_status_next = STATUS_OK;
        out_found_next  = '0;
        out_base_next   = '0;
        out_size_next   = '0;
        out_type_next   = TYPE_WC;
        out_low_next    = '0;
        out_high_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_WRITE:
                    begin
                        done          = out_free;
                        tbl_we        = out_free && ({1'b0, idx_reg} < NUM_ENTRIES_CNT);
                        out_low_next  = enc_low;
                        out_high_next = enc_high;
                    end
                    CMD_READ:
                    begin
                        done          = out_free;
                        out_base_next = rd_high[WORD_W-1:PAGE_BITS];
                        out_size_next = PAGE_NUM_W'(~rd_low[WORD_W-1:PAGE_BITS] + 1'b1);
                        out_type_next = dec_type;
                    end
                    CMD_FIND_FREE:
                    begin
                        if (pref_ok)
                        begin
                            done           = out_free;
                            out_found_next = rep_reg[IDX_W-1:0];
                        end
                        else if (max_cnt == '0)
                        begin
                            done            = out_free;
                            out_status_next = STATUS_NO_SPACE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                        end
                    end
                    CMD_LOAD_RAW:
                    begin
                        done    = out_free;
                        tbl_we  = out_free && ({1'b0, idx_reg} < NUM_ENTRIES_CNT);
                        wr_low  = rlo_reg;
                        wr_high = rhi_reg;
                    end
                    CMD_VALIDATE:
                    begin
                        done = out_free;
                        if ((type_reg != TYPE_WC) && (!mode_reg || (type_reg != TYPE_UC)))
                            out_status_next = STATUS_BAD_TYPE;
                    end
                    default:
                    begin
                        done = out_free;
                    end
                endcase
                if (done)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    done           = out_free;
                    out_found_next = cnt_reg[IDX_W-1:0];
                end
                else if ((cnt_reg + 1'b1) >= max_cnt)
                begin
                    done            = out_free;
                    out_status_next = STATUS_NO_SPACE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= 1'b0;
            rmask_reg      <= '0;
            riu_reg        <= RANGES_RESET;
            cmd_reg        <= '0;
            idx_reg        <= '0;
            base_reg       <= '0;
            size_reg       <= '0;
            type_reg       <= '0;
            rep_reg        <= '0;
            rlo_reg        <= '0;
            rhi_reg        <= '0;
            out_status_reg <= '0;
            out_found_reg  <= '0;
            out_base_reg   <= '0;
            out_size_reg   <= '0;
            out_type_reg   <= '0;
            out_low_reg    <= '0;
            out_high_reg   <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                low_mem[i]  <= '0;
                high_mem[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (s_tvalid && s_tready)
            begin
                cmd_reg  <= s_tuser;
                idx_reg  <= s_tdata[2:0];
                base_reg <= s_tdata[22:3];
                size_reg <= s_tdata[42:23];
                type_reg <= s_tdata[44:43];
                rep_reg  <= s_tdata[48:45];
                rlo_reg  <= s_tdata[80:49];
                rhi_reg  <= s_tdata[112:81];
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MCR_MODE:      mode_reg  <= cfg_data[0];
                    CFG_RESERVED_MASK: rmask_reg <= cfg_data;
                    CFG_RANGES_IN_USE: riu_reg   <= cfg_data[CNT_W-1:0];
                    default:           ;
                endcase
            end

            if (tbl_we)
            begin
                low_mem[idx_reg[AW-1:0]]  <= wr_low;
                high_mem[idx_reg[AW-1:0]] <= wr_high;
            end

            if (done)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= out_status_next;
                out_found_reg  <= out_found_next;
                out_base_reg   <= out_base_next;
                out_size_reg   <= out_size_next;
                out_type_reg   <= out_type_next;
                out_low_reg    <= out_low_next;
                out_high_reg   <= out_high_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/mrrt_checker.sv
`include "assert_macros.svh"

module mrrt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic [mrrt_pkg::IN_DATA_W-1:0]    s_tdata,
    input logic [mrrt_pkg::CMD_W-1:0]        s_tuser,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [mrrt_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic                              cfg_we,
    input logic [mrrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [mrrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mrrt_pkg::*;

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One command at a time: the input closes right after a transfer.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A failed free search reports entry zero.
    `ASSERT_IMPLY(a_no_space_index, clk, rst_n,
        m_tvalid && (m_tdata[1:0] == STATUS_NO_SPACE), m_tdata[4:2] == '0)

    // An error status never comes with decoded or encoded data.
    `ASSERT_IMPLY(a_error_clean, clk, rst_n,
        m_tvalid && (m_tdata[1:0] != STATUS_OK), m_tdata[OUT_DATA_W-1:5] == '0)

endmodule

bind memory_range_register_table mrrt_checker u_mrrt_checker (.*);
